// ===== rtl/ffba_pkg.sv =====
// Shared types and constants of the first-fit block allocator.
`default_nettype none
package ffba_pkg;

    localparam int MAX_BLOCKS      = 64;
    localparam int HEADER_BYTES    = 20;
    localparam int MIN_SPLIT_BYTES = 32;

    localparam int ADDR_W = 32;
    localparam int OFFS_W = 24;
    localparam int SIZE_W = 25;
    localparam int NEED_W = 33;

    localparam logic [ADDR_W-1:0] HEAP_BASE_RESET  = 32'h0050_0000;
    localparam logic [SIZE_W-1:0] HEAP_BYTES_RESET = 25'h100_0000;
    localparam logic [SIZE_W-1:0] HEAP_MIN_BYTES   = 25'd64;
    localparam logic [SIZE_W-1:0] HEAP_MAX_BYTES   = 25'h100_0000;
    localparam logic [SIZE_W-1:0] HEAD_SIZE_RESET  =
        SIZE_W'(HEAP_BYTES_RESET - SIZE_W'(HEADER_BYTES));

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_INIT  = 2'd2,
        OP_RSVD  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OOM     = 2'd1,
        ST_IGNORED = 2'd2,
        ST_INVALID = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_INIT,
        CMD_ALLOC,
        CMD_CLEAR,
        CMD_MERGE_NEXT,
        CMD_MERGE_PREV
    } cmd_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_SEARCH,
        FSM_MNEXT,
        FSM_MPREV,
        FSM_OUT
    } fsm_t;

    typedef struct packed {
        logic              valid;
        logic              used;
        logic [OFFS_W-1:0] offset;
        logic [SIZE_W-1:0] size;
    } blk_t;

    typedef struct packed {
        cmd_t              cmd;
        logic              split;
        logic [NEED_W-1:0] need;
        logic [SIZE_W-1:0] init_size;
    } ctrl_t;

    typedef struct packed {
        logic fit;
        logic room;
        logic match;
    } flags_t;

endpackage
`default_nettype wire

// ===== rtl/first_fit_block_allocator_core.sv =====
// Top level of the first-fit block allocator: chain of block cells plus sequencer.
//
//  channel | dir | transaction carries
//  --------+-----+---------------------------------------------------------------
//  s_      | in  | tuser: operation[1:0]; tdata: request_size[31:0], address[63:32]
//  m_      | out | tdata: result_address[31:0], status[33:32], zero pad to 40 bits
//  cfg_    | in  | index 0 heap_base, index 1 heap_bytes; write when cfg_we high
//
//  One item at a time. The search token walks one cell per cycle; an allocate or
//  free searches up to the slot of the hit, or to the end of the block list on a
//  miss, and a free then runs the merge-next and merge-prev steps.
//  Reinitialize, zero size, null address and unknown op skip the search.
//  Reset (aresetn low, synchronous) restores one free block covering the heap.
//  A result waiting on m_tready holds the sequencer; s_tready is low until then.
`default_nettype none
module first_fit_block_allocator_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // request_size[31:0], address[63:32]
    input  wire logic [1:0]  s_tuser,   // operation[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // result_address[31:0], status[33:32]
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_wdata
);
    import ffba_pkg::*;

    localparam int N = MAX_BLOCKS;

    // configuration
    logic [ADDR_W-1:0] heap_base_reg;
    logic [SIZE_W-1:0] heap_bytes_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_base_reg  <= HEAP_BASE_RESET;
            heap_bytes_reg <= HEAP_BYTES_RESET;
        end else if (cfg_we) begin
            if (cfg_index == 1'b0) begin
                heap_base_reg <= cfg_wdata;
            end else begin
                heap_bytes_reg <= cfg_wdata[SIZE_W-1:0];
            end
        end
    end

    // sequencer state
    fsm_t              fsm_reg, fsm_next;
    op_t               op_reg, op_next;
    logic [NEED_W-1:0] need_reg, need_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [N-1:0]      sel_reg, sel_next;    // one-hot search token
    logic [N-1:0]      done_reg, done_next;  // slots already passed by the token
    logic [ADDR_W-1:0] res_addr_reg, res_addr_next;
    status_t           res_status_reg, res_status_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [39:0]       m_tdata_reg, m_tdata_next;

    ctrl_t             ctrl;
    logic [SIZE_W-1:0] heap_total;

    // chain wiring
    blk_t   blk_q [N];
    flags_t flg   [N];
    logic [N-1:0] valid_vec, used_vec, fit_vec, room_vec, match_vec, after_vec;
    logic [OFFS_W-1:0] off_bus;

    assign after_vec = ~done_reg & ~sel_reg;

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            ffba_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .is_head    (g == 0),
                .ctrl       (ctrl),
                .heap_base  (heap_base_reg),
                .free_addr  (addr_reg),
                .sel_self   (sel_reg[g]),
                .sel_left   ((g == 0) ? 1'b0 : sel_reg[(g == 0) ? 0 : g-1]),
                .sel_right  ((g == N-1) ? 1'b0 : sel_reg[(g == N-1) ? g : g+1]),
                .after_self (after_vec[g]),
                .left       ((g == 0) ? blk_t'('0) : blk_q[(g == 0) ? 0 : g-1]),
                .right      ((g == N-1) ? blk_t'('0) : blk_q[(g == N-1) ? g : g+1]),
                .q          (blk_q[g]),
                .flags      (flg[g])
            );
            assign valid_vec[g] = blk_q[g].valid;
            assign used_vec[g]  = blk_q[g].used;
            assign fit_vec[g]   = flg[g].fit;
            assign room_vec[g]  = flg[g].room;
            assign match_vec[g] = flg[g].match;
        end
    endgenerate

    // offset of the slot under the token
    always_comb begin
        off_bus = '0;
        for (int i = 0; i < N; i++) begin
            off_bus = off_bus | (blk_q[i].offset & {OFFS_W{sel_reg[i]}});
        end
    end

    logic hit, live, room_hit, next_free, prev_free, table_full;
    assign hit        = (op_reg == OP_ALLOC) ? |(sel_reg & fit_vec) : |(sel_reg & match_vec);
    assign live       = |(sel_reg & valid_vec);
    assign room_hit   = |(sel_reg & room_vec);
    assign table_full = valid_vec[N-1];
    assign next_free  = |((sel_reg << 1) & valid_vec & ~used_vec);
    assign prev_free  = |((sel_reg >> 1) & ~used_vec);

    // single-block size, heap size clamped to its legal range
    always_comb begin
        heap_total = heap_bytes_reg;
        if (heap_total < HEAP_MIN_BYTES) heap_total = HEAP_MIN_BYTES;
        if (heap_total > HEAP_MAX_BYTES) heap_total = HEAP_MAX_BYTES;
    end

    assign s_tready = (fsm_reg == FSM_IDLE);

    // next state
    always_comb begin
        fsm_next = fsm_reg;
        case (fsm_reg)
            FSM_IDLE: begin
                if (s_tvalid) begin
                    if ((op_t'(s_tuser) == OP_ALLOC && s_tdata[31:0] != '0) ||
                        (op_t'(s_tuser) == OP_FREE && s_tdata[63:32] != '0)) begin
                        fsm_next = FSM_SEARCH;
                    end else begin
                        fsm_next = FSM_OUT;
                    end
                end
            end
            FSM_SEARCH: begin
                if (hit) begin
                    fsm_next = (op_reg == OP_ALLOC) ? FSM_OUT : FSM_MNEXT;
                end else if (!live) begin
                    fsm_next = FSM_OUT;
                end
            end
            FSM_MNEXT: fsm_next = FSM_MPREV;
            FSM_MPREV: fsm_next = FSM_OUT;
            FSM_OUT: begin
                if (!m_tvalid_reg || m_tready) fsm_next = FSM_IDLE;
            end
            default: fsm_next = FSM_IDLE;
        endcase
    end

    // outputs and datapath updates
    always_comb begin
        op_next         = op_reg;
        need_next       = need_reg;
        addr_next       = addr_reg;
        sel_next        = sel_reg;
        done_next       = done_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        m_tdata_next    = m_tdata_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        ctrl.cmd        = CMD_HOLD;
        ctrl.split      = 1'b0;
        ctrl.need       = need_reg;
        ctrl.init_size  = heap_total - SIZE_W'(HEADER_BYTES);
        case (fsm_reg)
            FSM_IDLE: begin
                if (s_tvalid) begin
                    op_next         = op_t'(s_tuser);
                    need_next       = ({1'b0, s_tdata[31:0]} + NEED_W'(7)) & ~NEED_W'(7);
                    addr_next       = s_tdata[63:32];
                    sel_next        = N'(1);
                    done_next       = '0;
                    res_addr_next   = '0;
                    res_status_next = ST_IGNORED;
                    if (op_t'(s_tuser) == OP_INIT) begin
                        ctrl.cmd        = CMD_INIT;
                        res_status_next = ST_OK;
                    end
                end
            end
            FSM_SEARCH: begin
                if (hit) begin
                    if (op_reg == OP_ALLOC) begin
                        ctrl.cmd        = CMD_ALLOC;
                        ctrl.split      = room_hit && !table_full;
                        res_addr_next   = heap_base_reg + ADDR_W'(off_bus)
                                          + ADDR_W'(HEADER_BYTES);
                        res_status_next = ST_OK;
                    end else begin
                        ctrl.cmd = CMD_CLEAR;
                    end
                end else if (!live) begin
                    res_status_next = (op_reg == OP_ALLOC) ? ST_OOM : ST_INVALID;
                end else begin
                    sel_next  = sel_reg << 1;
                    done_next = done_reg | sel_reg;
                end
            end
            FSM_MNEXT: begin
                if (next_free) ctrl.cmd = CMD_MERGE_NEXT;
            end
            FSM_MPREV: begin
                if (prev_free) ctrl.cmd = CMD_MERGE_PREV;
                res_status_next = ST_OK;
            end
            FSM_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'b0, res_status_reg, res_addr_reg};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg      <= FSM_IDLE;
            m_tvalid_reg <= 1'b0;
            sel_reg      <= '0;
            done_reg     <= '0;
        end else begin
            fsm_reg      <= fsm_next;
            m_tvalid_reg <= m_tvalid_next;
            sel_reg      <= sel_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        need_reg       <= need_next;
        addr_reg       <= addr_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        m_tdata_reg    <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // the token marks at most one slot
    a_token_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(sel_reg)) else $error("search token not one-hot");

    // the token never sits on a slot already passed
    a_token_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (sel_reg & done_reg) == '0) else $error("token overlaps passed slots");

    // live blocks form a contiguous run starting at slot 0
    a_valid_run: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_vec[0] && ((valid_vec & (valid_vec + N'(1))) == '0))
        else $error("block table not contiguous");

    // a result is only produced from the output state
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(fsm_reg) == FSM_OUT)
        else $error("result raised outside output state");

endmodule
`default_nettype wire

// ===== rtl/ffba_cell.sv =====
// One table slot of the allocator chain: holds a block and shifts with its neighbors.
`default_nettype none
module ffba_cell (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          is_head,
    input  wire ffba_pkg::ctrl_t               ctrl,
    input  wire logic [ffba_pkg::ADDR_W-1:0]   heap_base,
    input  wire logic [ffba_pkg::ADDR_W-1:0]   free_addr,
    input  wire logic                          sel_self,
    input  wire logic                          sel_left,
    input  wire logic                          sel_right,
    input  wire logic                          after_self,
    input  wire ffba_pkg::blk_t                left,
    input  wire ffba_pkg::blk_t                right,
    output ffba_pkg::blk_t                     q,
    output ffba_pkg::flags_t                   flags
);
    import ffba_pkg::*;

    blk_t              blk_reg, blk_next;
    logic [SIZE_W-1:0] merged;
    logic [OFFS_W-1:0] rem_offset;
    logic [SIZE_W-1:0] rem_size;

    assign merged     = blk_reg.size + SIZE_W'(HEADER_BYTES) + right.size;
    assign rem_offset = left.offset + OFFS_W'(HEADER_BYTES) + ctrl.need[OFFS_W-1:0];
    assign rem_size   = left.size - ctrl.need[SIZE_W-1:0] - SIZE_W'(HEADER_BYTES);

    // flags only matter in the slot holding the search token
    assign flags.fit   = blk_reg.valid && !blk_reg.used
                         && ({{(NEED_W-SIZE_W){1'b0}}, blk_reg.size} >= ctrl.need);
    assign flags.room  = ({{(NEED_W+1-SIZE_W){1'b0}}, blk_reg.size} >=
                          ({1'b0, ctrl.need} + (NEED_W+1)'(HEADER_BYTES + MIN_SPLIT_BYTES)));
    assign flags.match = blk_reg.valid &&
                         ((heap_base + ADDR_W'(blk_reg.offset) + ADDR_W'(HEADER_BYTES))
                          == free_addr);

    always_comb begin
        blk_next = blk_reg;
        case (ctrl.cmd)
            CMD_INIT: begin
                blk_next.valid  = is_head;
                blk_next.used   = 1'b0;
                blk_next.offset = '0;
                blk_next.size   = is_head ? ctrl.init_size : '0;
            end
            CMD_ALLOC: begin
                if (sel_self) begin
                    blk_next.used = 1'b1;
                    if (ctrl.split) begin
                        blk_next.size = ctrl.need[SIZE_W-1:0];
                    end
                end else if (ctrl.split && sel_left) begin
                    blk_next.valid  = 1'b1;
                    blk_next.used   = 1'b0;
                    blk_next.offset = rem_offset;
                    blk_next.size   = rem_size;
                end else if (ctrl.split && after_self) begin
                    blk_next = left;
                end
            end
            CMD_CLEAR: begin
                if (sel_self) begin
                    blk_next.used = 1'b0;
                end
            end
            CMD_MERGE_NEXT: begin
                if (sel_self) begin
                    blk_next.size = merged;
                end else if (after_self) begin
                    blk_next = right;
                end
            end
            CMD_MERGE_PREV: begin
                if (sel_right) begin
                    blk_next.size = merged;
                end else if (sel_self || after_self) begin
                    blk_next = right;
                end
            end
            default: begin
                blk_next = blk_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blk_reg.valid  <= is_head;
            blk_reg.used   <= 1'b0;
            blk_reg.offset <= '0;
            blk_reg.size   <= is_head ? HEAD_SIZE_RESET : '0;
        end else begin
            blk_reg <= blk_next;
        end
    end

    assign q = blk_reg;

endmodule
`default_nettype wire
